/* sv/ufes_pkg.sv */
package ufes_pkg;

  // graph geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned NODE_W      = $clog2(TABLE_DEPTH);

  // field and register widths
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned NCOUNT_W   = 11;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 16;

  // register reset values
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST  = NCOUNT_W'(1024);
  localparam logic [WORD_W-1:0]   SEED_RST        = WORD_W'(1337);
  localparam logic [WORD_W-1:0]   SEED_ZERO_SUB   = WORD_W'(1337);
  localparam logic [WORD_W-1:0]   EXTRA_THR_RST   = WORD_W'(1073741792);
  localparam logic [CNT_W-1:0]    EXTRA_LIMIT_RST = CNT_W'(3072);
  localparam logic [CNT_W-1:0]    EDGE_LIMIT_RST  = CNT_W'(4096);

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NODE_COUNT  = 3'd0,
    CFG_SEED        = 3'd1,
    CFG_EXTRA_THR   = 3'd2,
    CFG_EXTRA_LIMIT = 3'd3,
    CFG_EDGE_LIMIT  = 3'd4
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_FIND_P,
    ST_FIND_GP,
    ST_DECIDE
  } state_t;

  // one xorshift32 step
  function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

/* sv/union_find_edge_selector.sv */
// union-find edge selector: takes one candidate edge per transfer and answers
// with one result transfer saying whether the edge is kept, whether it joined
// two sets, whether an endpoint was out of range, and the kept count so far.
// both endpoints are resolved to their roots by path-halving finds that walk a
// 1024-entry parent table held in a single-port-write, registered-read ram;
// every table access goes through that one ram under a small sequencer, so an
// item passes in order through a start read, the node_a find, a start read,
// the node_b find and a decide step; an edge with an endpoint out of range
// goes from its start read straight to decide. an item whose result finds the
// previous result still waiting on the output side holds in its decide step
// until that one leaves. an item with new_graph set first rewrites the whole
// parent table to identity, one entry per cycle; the same clearing pass runs
// after reset, and no input transfer is taken until it is done. the input
// side is ready again as soon as a result is registered, even while that
// result still waits on the output side.
// configuration writes are taken any cycle; seed takes effect at the next
// new_graph item.
module union_find_edge_selector (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ufes_pkg::IN_DATA_W-1:0]        in_tdata,   // node_a[9:0], node_b[19:10], zero pad
  input  logic [ufes_pkg::IN_USER_W-1:0]        in_tuser,   // new_graph[0]
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ufes_pkg::OUT_DATA_W-1:0]       out_tdata,  // kept[0], joined_sets[1],
                                                            // out_of_range[2], kept_total[15:3]
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [ufes_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [ufes_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import ufes_pkg::*;

  // configuration registers
  logic [NCOUNT_W-1:0] node_count_r;
  logic [WORD_W-1:0]   seed_r;
  logic [WORD_W-1:0]   extra_thr_r;
  logic [CNT_W-1:0]    extra_limit_r;
  logic [CNT_W-1:0]    edge_limit_r;

  // sequencer and datapath registers
  state_t              state_r,     state_nxt;
  logic [NODE_W-1:0]   clr_idx_r,   clr_idx_nxt;
  logic                phase_r,     phase_nxt;     // 0: finding node_a, 1: node_b
  logic                pend_r,      pend_nxt;      // an accepted item is in flight
  logic                oor_r,       oor_nxt;
  logic [NODE_W-1:0]   cur_x_r,     cur_x_nxt;
  logic [NODE_W-1:0]   cur_p_r,     cur_p_nxt;
  logic [NODE_W-1:0]   node_b_r,    node_b_nxt;
  logic [NODE_W-1:0]   root_a_r,    root_a_nxt;
  logic [NODE_W-1:0]   root_b_r,    root_b_nxt;
  logic [WORD_W-1:0]   rng_r,       rng_nxt;
  logic [CNT_W-1:0]    cnt_r,       cnt_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_kept_r,  out_kept_nxt;
  logic                out_join_r,  out_join_nxt;
  logic                out_oor_r,   out_oor_nxt;
  logic [CNT_W-1:0]    out_total_r, out_total_nxt;

  // parent table port
  logic                ram_we;
  logic [NODE_W-1:0]   ram_waddr;
  logic [NODE_W-1:0]   ram_wdata;
  logic [NODE_W-1:0]   ram_raddr;
  logic [NODE_W-1:0]   ram_rdata;

  // input fields
  logic                in_new_graph;
  logic [NODE_W-1:0]   in_node_a;
  logic [NODE_W-1:0]   in_node_b;

  assign in_new_graph = in_tuser[0];
  assign in_node_a    = in_tdata[NODE_W-1:0];
  assign in_node_b    = in_tdata[2*NODE_W-1:NODE_W];

  ufes_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_parent_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= NODE_COUNT_RST;
      seed_r        <= SEED_RST;
      extra_thr_r   <= EXTRA_THR_RST;
      extra_limit_r <= EXTRA_LIMIT_RST;
      edge_limit_r  <= EDGE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NODE_COUNT:  node_count_r  <= cfg_wdata[NCOUNT_W-1:0];
        CFG_SEED:        seed_r        <= cfg_wdata[WORD_W-1:0];
        CFG_EXTRA_THR:   extra_thr_r   <= cfg_wdata[WORD_W-1:0];
        CFG_EXTRA_LIMIT: extra_limit_r <= cfg_wdata[CNT_W-1:0];
        CFG_EDGE_LIMIT:  edge_limit_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // state register, control state is reset, payload is not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      phase_r     <= 1'b0;
      pend_r      <= 1'b0;
      oor_r       <= 1'b0;
      rng_r       <= SEED_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      oor_r       <= oor_nxt;
      rng_r       <= rng_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_p_r     <= cur_p_nxt;
    node_b_r    <= node_b_nxt;
    root_a_r    <= root_a_nxt;
    root_b_r    <= root_b_nxt;
    out_kept_r  <= out_kept_nxt;
    out_join_r  <= out_join_nxt;
    out_oor_r   <= out_oor_nxt;
    out_total_r <= out_total_nxt;
  end

  // sequencer: next state, table port and result
  always_comb begin
    logic              root_hit;
    logic [NODE_W-1:0] root;
    logic              joined;
    logic [WORD_W-1:0] draw;
    logic              take;

    root_hit = 1'b0;
    root     = cur_x_r;
    joined   = root_a_r != root_b_r;
    draw     = xorshift32(rng_r);
    take     = 1'b0;

    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    oor_nxt       = oor_r;
    cur_x_nxt     = cur_x_r;
    cur_p_nxt     = cur_p_r;
    node_b_nxt    = node_b_r;
    root_a_nxt    = root_a_r;
    root_b_nxt    = root_b_r;
    rng_nxt       = rng_r;
    cnt_nxt       = cnt_r;
    out_kept_nxt  = out_kept_r;
    out_join_nxt  = out_join_r;
    out_oor_nxt   = out_oor_r;
    out_total_nxt = out_total_r;

    ram_we    = 1'b0;
    ram_waddr = cur_x_r;
    ram_wdata = ram_rdata;
    ram_raddr = cur_x_r;

    in_tready = state_r == ST_IDLE;

    // result register drains independently of the sequencer
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      // identity fill, one entry per cycle
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == NODE_W'(TABLE_DEPTH - 1)) begin
          state_nxt = pend_r ? ST_START : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          cur_x_nxt  = in_node_a;
          node_b_nxt = in_node_b;
          phase_nxt  = 1'b0;
          pend_nxt   = 1'b1;
          oor_nxt    = ({1'b0, in_node_a} >= node_count_r) ||
                       ({1'b0, in_node_b} >= node_count_r);
          if (in_new_graph) begin
            cnt_nxt     = '0;
            rng_nxt     = (seed_r == '0) ? SEED_ZERO_SUB : seed_r;
            clr_idx_nxt = '0;
            state_nxt   = ST_CLEAR;
          end else begin
            state_nxt = ST_START;
          end
        end
      end

      // issue the first read of a find
      ST_START: begin
        ram_raddr = cur_x_r;
        state_nxt = oor_r ? ST_DECIDE : ST_FIND_P;
      end

      // read data is parent of cur_x
      ST_FIND_P: begin
        if (ram_rdata == cur_x_r) begin
          root_hit = 1'b1;
          root     = cur_x_r;
        end else begin
          cur_p_nxt = ram_rdata;
          ram_raddr = ram_rdata;
          state_nxt = ST_FIND_GP;
        end
      end

      // read data is grandparent, halve the path
      ST_FIND_GP: begin
        if (ram_rdata == cur_p_r) begin
          root_hit = 1'b1;
          root     = cur_p_r;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cur_x_r;
          ram_wdata = ram_rdata;
          cur_x_nxt = ram_rdata;
          ram_raddr = ram_rdata;
          state_nxt = ST_FIND_P;
        end
      end

      ST_DECIDE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_oor_nxt   = oor_r;
          out_join_nxt  = 1'b0;
          out_kept_nxt  = 1'b0;
          if (!oor_r) begin
            out_join_nxt = joined;
            if (joined) begin
              take = 1'b1;
            end else begin
              rng_nxt = draw;
              take    = (draw < extra_thr_r) && (cnt_r < extra_limit_r);
            end
            if (take && (cnt_r < edge_limit_r)) begin
              out_kept_nxt = 1'b1;
              cnt_nxt      = cnt_r + 1'b1;
              if (joined) begin
                ram_we    = 1'b1;
                ram_waddr = root_a_r;
                ram_wdata = root_b_r;
              end
            end
          end
          out_total_nxt = out_kept_nxt ? cnt_r + 1'b1 : cnt_r;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a root found ends the find of node_a or of node_b
    if (root_hit) begin
      if (!phase_r) begin
        root_a_nxt = root;
        phase_nxt  = 1'b1;
        cur_x_nxt  = node_b_r;
        state_nxt  = ST_START;
      end else begin
        root_b_nxt = root;
        state_nxt  = ST_DECIDE;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_oor_r, out_join_r, out_kept_r};

  // table is written only by the fill, a path-halving step or a link
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_FIND_GP || state_r == ST_DECIDE))
    else $error("parent table written outside fill, find or link");

  // a halving write never hits the address read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == ST_FIND_GP) |-> (ram_waddr != ram_raddr))
    else $error("halving write collides with table read");

  // kept count only steps by one or restarts at a new graph
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + 1'b1 || cnt_r == '0))
    else $error("kept count jumped");

  // an out of range edge is neither kept nor joined
  a_oor_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (!out_kept_r && !out_join_r))
    else $error("out of range edge reported as kept or joined");

  // no item taken while one is in flight
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !pend_r)
    else $error("input taken with an item in flight");

endmodule

/* sv/ufes_ram.sv */
module ufes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
